// File: design/gtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtm_pkg: shared definitions of the gated trimmed mean filter
// defaults, register map, state encoding and control structs
// ----------------------------------------------------------------------------
package gtm_pkg;

  // default geometry
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned WINDOW_DEF      = 8;

  // quarter degrees to 1/256 degree
  localparam int unsigned MEAN_SHIFT = 6;

  // register fields
  localparam int unsigned STEP_BITS = 12;
  localparam int unsigned REJ_BITS  = 4;
  localparam int unsigned TRIM_BITS = 2;
  localparam int unsigned TRIM_MAX  = 3;

  localparam logic [STEP_BITS-1:0] MAX_STEP_RST    = 12'd48;
  localparam logic [REJ_BITS-1:0]  MAX_REJECTS_RST = 4'd4;
  localparam logic [TRIM_BITS-1:0] TRIM_COUNT_RST  = 2'd2;

  // configuration port
  localparam int unsigned PADDR_BITS = 4;
  localparam int unsigned PDATA_BITS = 32;

  localparam logic [1:0] REG_MAX_STEP    = 2'd0;
  localparam logic [1:0] REG_MAX_REJECTS = 2'd1;
  localparam logic [1:0] REG_TRIM_COUNT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TRIM,
    ST_DIV,
    ST_DONE
  } gtm_state_e;

  typedef struct packed {
    logic clear;
    logic push;
  } stats_ctrl_t;

endpackage : gtm_pkg
`default_nettype wire

// File: design/gtm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtm_in_if: sample request channel
// valid/ready handshake carrying one converter reading
// ----------------------------------------------------------------------------
interface gtm_in_if #(
  parameter int unsigned SAMPLE_BITS = gtm_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_temp;
  logic                   open_circuit;

  modport source (output valid, raw_temp, open_circuit, input ready);
  modport sink   (input valid, raw_temp, open_circuit, output ready);
endinterface : gtm_in_if
`default_nettype wire

// File: design/gtm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtm_out_if: result request channel
// valid/ready handshake carrying one filtered temperature
// ----------------------------------------------------------------------------
interface gtm_out_if #(
  parameter int unsigned SAMPLE_BITS = gtm_pkg::SAMPLE_BITS_DEF
);
  logic                                        valid;
  logic                                        ready;
  logic [SAMPLE_BITS+gtm_pkg::MEAN_SHIFT-1:0] mean_temp;
  logic                                        mean_valid;
  logic                                        sample_held;

  modport source (output valid, mean_temp, mean_valid, sample_held, input ready);
  modport sink   (input valid, mean_temp, mean_valid, sample_held, output ready);
endinterface : gtm_out_if
`default_nettype wire

// File: design/gtm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtm_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module gtm_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule : gtm_ram
`default_nettype wire

// File: design/gtm_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtm_stats: streaming window statistics
// running sum plus the three smallest and three largest entries, trimmed sum
// ----------------------------------------------------------------------------
module gtm_stats #(
  parameter int unsigned SAMPLE_BITS = gtm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned WINDOW      = gtm_pkg::WINDOW_DEF
) (
  input  wire logic                                   clk_i,
  input  wire gtm_pkg::stats_ctrl_t                   ctrl_i,
  input  wire logic [SAMPLE_BITS-1:0]                 data_i,
  input  wire logic [$clog2(WINDOW+1)-1:0]            fill_i,
  input  wire logic [gtm_pkg::TRIM_BITS-1:0]          trim_i,
  output logic      [SAMPLE_BITS+$clog2(WINDOW+1)-1:0] sum_o,
  output logic      [$clog2(WINDOW+1)-1:0]            cnt_o
);
  import gtm_pkg::*;

  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned SUMW = SAMPLE_BITS + CW;

  logic [SUMW-1:0]        sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] lo_q [TRIM_MAX];
  logic [SAMPLE_BITS-1:0] lo_d [TRIM_MAX];
  logic [SAMPLE_BITS-1:0] hi_q [TRIM_MAX];
  logic [SAMPLE_BITS-1:0] hi_d [TRIM_MAX];
  logic [TRIM_BITS-1:0]   lo_cut;
  logic [SUMW-1:0]        trimmed;

  // sorted insertion into the small and large lists
  always_comb begin
    sum_d = sum_q;
    for (int i = 0; i < TRIM_MAX; i++) begin
      lo_d[i] = lo_q[i];
      hi_d[i] = hi_q[i];
    end
    if (ctrl_i.clear) begin
      sum_d = '0;
      for (int i = 0; i < TRIM_MAX; i++) begin
        lo_d[i] = '1;
        hi_d[i] = '0;
      end
    end else if (ctrl_i.push) begin
      sum_d = sum_q + SUMW'(data_i);
      lo_d[0] = (data_i < lo_q[0]) ? data_i : lo_q[0];
      hi_d[0] = (data_i > hi_q[0]) ? data_i : hi_q[0];
      for (int i = 1; i < TRIM_MAX; i++) begin
        lo_d[i] = (data_i < lo_q[i-1]) ? lo_q[i-1] :
                  ((data_i < lo_q[i]) ? data_i : lo_q[i]);
        hi_d[i] = (data_i > hi_q[i-1]) ? hi_q[i-1] :
                  ((data_i > hi_q[i]) ? data_i : hi_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    for (int i = 0; i < TRIM_MAX; i++) begin
      lo_q[i] <= lo_d[i];
      hi_q[i] <= hi_d[i];
    end
  end

  // trim only when at least one entry is left
  assign lo_cut = (8'(fill_i) >= 8'({trim_i, 1'b1})) ? trim_i : '0;

  always_comb begin
    trimmed = sum_q;
    for (int i = 0; i < TRIM_MAX; i++) begin
      if (TRIM_BITS'(i) < lo_cut) begin
        trimmed = trimmed - SUMW'(lo_q[i]) - SUMW'(hi_q[i]);
      end
    end
  end

  assign sum_o = trimmed;
  assign cnt_o = fill_i - CW'({lo_cut, 1'b0});
endmodule : gtm_stats
`default_nettype wire

// File: design/gtm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtm_div: restoring divider
// one quotient bit per cycle, small divisor
// ----------------------------------------------------------------------------
module gtm_div #(
  parameter int unsigned DW = 22,
  parameter int unsigned CW = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [CW-1:0] divisor_i,
  output logic      [DW-1:0] quotient_o,
  output logic               done_o
);
  localparam int unsigned NW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] div_q, div_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [CW:0]   trial;
  logic [CW:0]   diff;
  logic          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[CW-1:0] : trial[CW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == NW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;
endmodule : gtm_div
`default_nettype wire

// File: design/gated_trimmed_mean_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gated_trimmed_mean_filter: thermocouple outlier gate and trimmed mean
// gates each reading, stores it in a ring ram and returns the trimmed mean
// ----------------------------------------------------------------------------
// sequence: after accept, one ram read per filled entry, a trim step, then the
//   bit-serial divider before the result is loaded; an open probe skips the
//   reads and the divider
// requests: one at a time, the next accepted once the result is in the
//   output register
// reset: asynchronous active low; clears the ring fill, gate state and
//   registers to their defaults; the ring ram itself is not cleared
module gated_trimmed_mean_filter #(
  parameter int unsigned SAMPLE_BITS = gtm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned WINDOW      = gtm_pkg::WINDOW_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  gtm_in_if.sink                                sample_i,
  gtm_out_if.source                             result_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [gtm_pkg::PADDR_BITS-1:0]   paddr,
  input  wire logic [gtm_pkg::PDATA_BITS-1:0]   pwdata,
  output logic      [gtm_pkg::PDATA_BITS-1:0]   prdata,
  output logic                                  pready
);
  import gtm_pkg::*;

  localparam int unsigned CW        = $clog2(WINDOW + 1);
  localparam int unsigned AW        = $clog2(WINDOW);
  localparam int unsigned SUMW      = SAMPLE_BITS + CW;
  localparam int unsigned DW        = SUMW + MEAN_SHIFT;
  localparam int unsigned MEAN_BITS = SAMPLE_BITS + MEAN_SHIFT;
  localparam int unsigned CMPW      = (SAMPLE_BITS > STEP_BITS) ? SAMPLE_BITS : STEP_BITS;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [STEP_BITS-1:0] max_step_q;
  logic [REJ_BITS-1:0]  max_rejects_q;
  logic [TRIM_BITS-1:0] trim_count_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q    <= MAX_STEP_RST;
      max_rejects_q <= MAX_REJECTS_RST;
      trim_count_q  <= TRIM_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MAX_STEP:    max_step_q    <= pwdata[STEP_BITS-1:0];
        REG_MAX_REJECTS: max_rejects_q <= pwdata[REJ_BITS-1:0];
        REG_TRIM_COUNT:  trim_count_q  <= pwdata[TRIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_MAX_STEP:    prdata = PDATA_BITS'(max_step_q);
      REG_MAX_REJECTS: prdata = PDATA_BITS'(max_rejects_q);
      REG_TRIM_COUNT:  prdata = PDATA_BITS'(trim_count_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------------
  gtm_state_e state_q, state_d;

  logic                   accept;
  logic                   rd_issue;
  logic                   rd_done;
  logic                   div_start;
  logic                   div_done;
  logic                   out_load;
  logic                   in_ready;

  // gate and ring bookkeeping
  logic [CW-1:0]          fill_q, fill_d;
  logic [AW-1:0]          wpos_q, wpos_d;
  logic [SAMPLE_BITS-1:0] last_q, last_d;
  logic                   known_q, known_d;
  logic [REJ_BITS-1:0]    rej_q, rej_d;
  logic                   held_q, held_d;
  logic                   open_q, open_d;

  // ring read sweep
  logic [CW-1:0]          rd_cnt_q, rd_cnt_d;
  logic                   rd_vld_q;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [MEAN_BITS-1:0]   out_mean_q;
  logic                   out_mvalid_q;
  logic                   out_held_q;

  logic [SAMPLE_BITS-1:0] raw;
  logic                   open_in;
  logic [SAMPLE_BITS-1:0] diff;
  logic                   held_c;
  logic [SAMPLE_BITS-1:0] use_c;
  logic                   ring_we;

  logic [SAMPLE_BITS-1:0] ring_rdata;
  stats_ctrl_t            stats_ctrl;
  logic [SUMW-1:0]        trim_sum;
  logic [CW-1:0]          trim_cnt;
  logic [DW-1:0]          quotient;

  assign raw     = sample_i.raw_temp;
  assign open_in = sample_i.open_circuit;
  assign accept  = sample_i.valid && in_ready;

  // ---------------------------------------------------------------------------
  // outlier gate: hold a large jump at the last accepted value, but only
  // max_rejects times in a row
  // ---------------------------------------------------------------------------
  assign diff   = (raw > last_q) ? (raw - last_q) : (last_q - raw);
  assign held_c = known_q && (CMPW'(diff) > CMPW'(max_step_q)) && (rej_q < max_rejects_q);
  assign use_c  = held_c ? last_q : raw;

  // the gated value goes into the ring in the accept cycle
  assign ring_we = accept && !open_in;

  always_comb begin
    fill_d  = fill_q;
    wpos_d  = wpos_q;
    last_d  = last_q;
    known_d = known_q;
    rej_d   = rej_q;
    held_d  = held_q;
    open_d  = open_q;
    if (accept) begin
      open_d = open_in;
      if (open_in) begin
        // open probe flushes the ring and clears the gate
        fill_d  = '0;
        wpos_d  = '0;
        last_d  = '0;
        known_d = 1'b0;
        rej_d   = '0;
        held_d  = 1'b0;
      end else begin
        held_d = held_c;
        if (held_c) begin
          rej_d = rej_q + 1'b1;
        end else begin
          rej_d   = '0;
          last_d  = raw;
          known_d = 1'b1;
        end
        wpos_d = (wpos_q == AW'(WINDOW - 1)) ? '0 : wpos_q + 1'b1;
        if (fill_q != CW'(WINDOW)) begin
          fill_d = fill_q + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign rd_done = !rd_issue && !rd_vld_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = open_in ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        if (rd_done) begin
          state_d = ST_TRIM;
        end
      end
      ST_TRIM: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready         = 1'b0;
    rd_issue         = 1'b0;
    div_start        = 1'b0;
    out_load         = 1'b0;
    stats_ctrl.clear = 1'b0;
    stats_ctrl.push  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready         = 1'b1;
        stats_ctrl.clear = accept;
      end
      ST_READ: begin
        rd_issue        = rd_cnt_q < fill_q;
        stats_ctrl.push = rd_vld_q;
      end
      ST_TRIM: div_start = 1'b1;
      ST_DIV:  ;
      ST_DONE: out_load = !out_valid_q || result_o.ready;
      default: ;
    endcase
  end

  assign sample_i.ready = in_ready;

  // read sweep over the filled entries, one per cycle
  always_comb begin
    rd_cnt_d = rd_cnt_q;
    if (accept) begin
      rd_cnt_d = '0;
    end else if (rd_issue) begin
      rd_cnt_d = rd_cnt_q + 1'b1;
    end
  end

  // result register: a finished result waits here while the next request runs
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      wpos_q      <= '0;
      last_q      <= '0;
      known_q     <= 1'b0;
      rej_q       <= '0;
      held_q      <= 1'b0;
      open_q      <= 1'b0;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      wpos_q      <= wpos_d;
      last_q      <= last_d;
      known_q     <= known_d;
      rej_q       <= rej_d;
      held_q      <= held_d;
      open_q      <= open_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_vld_q    <= rd_issue;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, zero mean after an open probe
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mean_q   <= open_q ? '0 : quotient[MEAN_BITS-1:0];
      out_mvalid_q <= !open_q;
      out_held_q   <= held_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.mean_temp   = out_mean_q;
  assign result_o.mean_valid  = out_mvalid_q;
  assign result_o.sample_held = out_held_q;

  // ---------------------------------------------------------------------------
  // datapath units
  // ---------------------------------------------------------------------------
  gtm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wpos_q),
    .wdata_i (use_c),
    .re_i    (rd_issue),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (ring_rdata)
  );

  gtm_stats #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WINDOW      (WINDOW)
  ) u_stats (
    .clk_i  (clk_i),
    .ctrl_i (stats_ctrl),
    .data_i (ring_rdata),
    .fill_i (fill_q),
    .trim_i (trim_count_q),
    .sum_o  (trim_sum),
    .cnt_o  (trim_cnt)
  );

  // mean = trimmed sum * 64 / count
  gtm_div #(
    .DW (DW),
    .CW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({trim_sum, {MEAN_SHIFT{1'b0}}}),
    .divisor_i  (trim_cnt),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(WINDOW))
    else $error("ring fill count beyond window");

  a_read_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_issue |-> (rd_cnt_q < fill_q) && (state_q == ST_READ))
    else $error("ring read outside the filled entries");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || result_o.ready)
    else $error("pending result overwritten");

  a_open_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && open_in |=> fill_q == '0 && !known_q && state_q == ST_DONE)
    else $error("open probe did not flush the ring");

endmodule : gated_trimmed_mean_filter
`default_nettype wire

// File: verif/gated_trimmed_mean_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_trimmed_mean_filter_test: self-checking bench of the thermocouple filter
// drives gated sample requests with random gaps and result stalls, predicts
// every trimmed mean, hold flag and open-probe result, checks them in order
// and reprograms the gate and trim registers over apb between phases
// ----------------------------------------------------------------------------
module gated_trimmed_mean_filter_test;

  import gtm_pkg::*;

  localparam int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int unsigned WINDOW      = WINDOW_DEF;
  localparam int unsigned MEAN_BITS   = SAMPLE_BITS + MEAN_SHIFT;
  localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

  // index with no register behind it, writes to it must be ignored
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // longer than one full window request takes, so this covers any tail
  localparam int unsigned DRAIN_CYCLES   = 40;
  // receiver hold-off long enough to back the block up into its input
  localparam int unsigned LONG_HOLD      = 300;
  // cycles with no request moving: long hold + drain + apb setup, several times
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw_temp;
    logic                   open_circuit;
  } sample_t;

  typedef struct packed {
    logic [MEAN_BITS-1:0] mean_temp;
    logic                 mean_valid;
    logic                 sample_held;
  } mean_result_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // apb configuration port
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  gtm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) sample_if ();
  gtm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) result_if ();

  gated_trimmed_mean_filter #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WINDOW      (WINDOW)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------------------
  // filter state as the bench believes it to be
  // ---------------------------------------------------------------------------
  logic [STEP_BITS-1:0]   step_limit   = MAX_STEP_RST;
  logic [REJ_BITS-1:0]    reject_limit = MAX_REJECTS_RST;
  logic [TRIM_BITS-1:0]   trim_drop    = TRIM_COUNT_RST;

  logic [SAMPLE_BITS-1:0] ring_q [WINDOW];
  int unsigned            ring_fill   = 0;
  int unsigned            ring_wpos   = 0;
  logic [SAMPLE_BITS-1:0] last_good   = '0;
  bit                     have_last   = 1'b0;
  int unsigned            reject_run  = 0;

  // pending sample requests and the results they must produce
  sample_t      sample_queue [$];
  mean_result_t expected_means [$];

  // handshake bookkeeping between the clocked processes
  bit           in_taken  = 1'b0;
  bit           out_taken = 1'b0;
  bit           idle_on   = 1'b1;
  bit           long_hold_armed = 1'b0;
  bit           long_hold_seen  = 1'b0;
  int unsigned  send_gap   = 0;
  int unsigned  recv_stall = 0;
  int unsigned  quiet_cycles = 0;
  sample_t      next_sample;
  mean_result_t predicted;
  mean_result_t expected_now;

  // random trace generator state
  int           trace_level = 1000;
  int           spike_left  = 0;
  int           spike_val   = 0;

  // run statistics
  int unsigned  mismatch_count   = 0;
  int unsigned  samples_taken    = 0;
  int unsigned  results_seen     = 0;
  int unsigned  holds_predicted  = 0;
  int unsigned  opens_taken      = 0;
  int unsigned  settings_applied = 0;

  // ---------------------------------------------------------------------------
  // prediction: gate, ring write and trimmed mean for one accepted request
  // ---------------------------------------------------------------------------
  function automatic mean_result_t filter_sample(input logic [SAMPLE_BITS-1:0] raw,
                                                 input logic is_open);
    mean_result_t           res;
    logic [SAMPLE_BITS-1:0] kept;
    logic [SAMPLE_BITS-1:0] jump;
    logic [SAMPLE_BITS-1:0] key;
    logic [SAMPLE_BITS-1:0] sorted [WINDOW];
    int unsigned            lo;
    int unsigned            hi;
    int unsigned            j;
    longint unsigned        total;
    res  = '0;
    kept = raw;
    // open probe: flush the ring and forget the gate, result is invalid
    if (is_open) begin
      ring_fill  = 0;
      ring_wpos  = 0;
      last_good  = '0;
      have_last  = 1'b0;
      reject_run = 0;
      return res;
    end
    // outlier gate, only once some value has been accepted
    if (have_last) begin
      jump = (raw > last_good) ? raw - last_good : last_good - raw;
      if (jump > step_limit && reject_run < reject_limit) begin
        reject_run++;
        kept = last_good;
        res.sample_held = 1'b1;
      end
    end
    if (!res.sample_held) begin
      reject_run = 0;
      last_good  = raw;
      have_last  = 1'b1;
    end
    ring_q[ring_wpos] = kept;
    ring_wpos = (ring_wpos + 1) % WINDOW;
    if (ring_fill < WINDOW) ring_fill++;
    // sort the filled part of the ring
    for (int i = 0; i < ring_fill; i++) sorted[i] = ring_q[i];
    for (int i = 1; i < ring_fill; i++) begin
      key = sorted[i];
      j   = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    // trim only when at least one entry survives
    lo    = (ring_fill >= 2 * trim_drop + 1) ? trim_drop : 0;
    hi    = ring_fill - lo;
    total = 0;
    for (int i = lo; i < hi; i++) total += sorted[i];
    res.mean_temp  = MEAN_BITS'((total << MEAN_SHIFT) / (hi - lo));
    res.mean_valid = 1'b1;
    return res;
  endfunction

  function automatic void check_field(input string field, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sample driver: offers queued requests at the falling edge, with gaps
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
    end else if (!sample_if.valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        sample_if.valid <= 1'b0;
      end else if (idle_on && sample_queue.size() != 0 && $urandom_range(0, 4) == 0) begin
        // gap burst, the current cycle included
        send_gap = $urandom_range(1, 12) - 1;
        sample_if.valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        next_sample = sample_queue.pop_front();
        sample_if.valid        <= 1'b1;
        sample_if.raw_temp     <= next_sample.raw_temp;
        sample_if.open_circuit <= next_sample.open_circuit;
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stall bursts plus one long hold-off when armed
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else if (long_hold_armed && !long_hold_seen) begin
      long_hold_seen = 1'b1;
      recv_stall     = LONG_HOLD - 1;
      result_if.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      result_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      recv_stall = $urandom_range(1, 12) - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted sample, checks every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken  = sample_if.valid && sample_if.ready;
      out_taken = result_if.valid && result_if.ready;
      if (in_taken) begin
        predicted = filter_sample(sample_if.raw_temp, sample_if.open_circuit);
        expected_means.push_back(predicted);
        samples_taken++;
        if (sample_if.open_circuit) opens_taken++;
        if (predicted.sample_held) holds_predicted++;
      end
      if (out_taken) begin
        results_seen++;
        if (expected_means.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] result with no sample pending: mean_temp %0d", $realtime,
                     result_if.mean_temp);
        end else begin
          expected_now = expected_means.pop_front();
          check_field("mean_temp", expected_now.mean_temp, result_if.mean_temp);
          check_field("mean_valid", expected_now.mean_valid, result_if.mean_valid);
          check_field("sample_held", expected_now.sample_held, result_if.sample_held);
        end
      end
      // watchdog: any request moving on either channel or on apb counts
      if (in_taken || out_taken || (psel && penable)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: nothing moved for %0d cycles, %0d results pending",
                 $realtime, quiet_cycles, expected_means.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_sample(input int raw, input bit is_open);
    sample_t s;
    s.raw_temp     = SAMPLE_BITS'(raw);
    s.open_circuit = is_open;
    sample_queue.push_back(s);
  endtask

  // one apb access, setup then access phase; write updates the predicted copy
  task automatic apb_access(input bit wr, input logic [1:0] idx,
                            input logic [PDATA_BITS-1:0] wdata,
                            output logic [PDATA_BITS-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_BITS'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    if (wr) begin
      case (idx)
        REG_MAX_STEP:    step_limit   = wdata[STEP_BITS-1:0];
        REG_MAX_REJECTS: reject_limit = wdata[REJ_BITS-1:0];
        REG_TRIM_COUNT:  trim_drop    = wdata[TRIM_BITS-1:0];
        default: ;
      endcase
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // program all three registers with junk above the fields, poke the unused
  // index, then read the three registers back
  task automatic setup_filter(input int unsigned step, input int unsigned rejects,
                              input int unsigned trim);
    logic [PDATA_BITS-1:0] rdata;
    apb_access(1'b1, REG_MAX_STEP, ($urandom & ~32'hFFF) | step, rdata);
    apb_access(1'b1, REG_MAX_REJECTS, ($urandom & ~32'hF) | rejects, rdata);
    apb_access(1'b1, REG_TRIM_COUNT, ($urandom & ~32'h3) | trim, rdata);
    apb_access(1'b1, REG_UNUSED, $urandom, rdata);
    apb_access(1'b0, REG_MAX_STEP, '0, rdata);
    check_field("max_step readback", step_limit, rdata[STEP_BITS-1:0]);
    apb_access(1'b0, REG_MAX_REJECTS, '0, rdata);
    check_field("max_rejects readback", reject_limit, rdata[REJ_BITS-1:0]);
    apb_access(1'b0, REG_TRIM_COUNT, '0, rdata);
    check_field("trim_count readback", trim_drop, rdata[TRIM_BITS-1:0]);
    settings_applied++;
  endtask

  // slowly wandering temperature with spikes, outlier runs, level steps,
  // wide noise and the odd open probe
  task automatic queue_trace(input int count);
    int pick;
    int walk;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      walk = int'(step_limit) + 4;
      if (spike_left > 0) begin
        spike_left--;
        push_sample(spike_val, 1'b0);
      end else if (pick < 3) begin
        push_sample($urandom_range(0, SAMPLE_MAX), 1'b1);
      end else if (pick < 9) begin
        // outlier run, long enough at times to outlast max_rejects
        spike_left = $urandom_range(0, 17);
        spike_val  = $urandom_range(0, SAMPLE_MAX);
        push_sample(spike_val, 1'b0);
      end else if (pick < 13) begin
        push_sample($urandom_range(0, SAMPLE_MAX), 1'b0);
      end else if (pick < 15) begin
        trace_level = $urandom_range(0, SAMPLE_MAX);
        push_sample(trace_level, 1'b0);
      end else begin
        trace_level = trace_level + $urandom_range(0, 2 * walk) - walk;
        if (trace_level < 0) trace_level = 0;
        if (trace_level > SAMPLE_MAX) trace_level = SAMPLE_MAX;
        push_sample(trace_level, 1'b0);
      end
    end
  endtask

  // block idle: every request sent, every result back, then a short tail
  task automatic wait_idle();
    while (sample_queue.size() != 0 || sample_if.valid || expected_means.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rnd_step;
    sample_if.valid        = 1'b0;
    sample_if.raw_temp     = '0;
    sample_if.open_circuit = 1'b0;
    result_if.ready        = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part at reset settings: step 48, 4 holds, trim 2
    push_sample(SAMPLE_MAX, 1'b0);  // nothing accepted yet, passes the gate
    repeat (4) push_sample(0, 1'b0); // held four times in a row
    push_sample(0, 1'b0);           // hold budget spent, jump accepted
    push_sample(48, 1'b0);          // jump exactly at the limit
    push_sample(97, 1'b0);          // one over the limit, held
    push_sample(49, 1'b0);          // ring wraps here
    push_sample(2048, 1'b0);
    push_sample(SAMPLE_MAX, 1'b1);  // open probe with a full-scale reading
    push_sample(0, 1'b1);           // open probe twice in a row
    push_sample(2048, 1'b0);        // after a flush anything passes
    push_sample(2050, 1'b0);        // too few entries to trim
    push_sample(2040, 1'b0);
    push_sample(2060, 1'b0);
    push_sample(2045, 1'b0);        // first window wide enough to trim
    push_sample(2055, 1'b0);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(0, 1'b0);
    push_sample(2052, 1'b0);
    push_sample(2049, 1'b0);
    push_sample(2051, 1'b0);
    push_sample(2047, 1'b0);
    push_sample(0, 1'b1);
    wait_idle();

    // widest gate, longest hold budget, deepest trim
    setup_filter(SAMPLE_MAX, 15, TRIM_MAX);
    queue_trace(80);
    wait_idle();

    // tightest step but no hold budget, no trim; long result hold-off here
    setup_filter(0, 0, 0);
    long_hold_armed = 1'b1;
    queue_trace(80);
    wait_idle();

    // almost everything held, a stretch with no idling at all
    idle_on = 1'b0;
    setup_filter(0, 15, 1);
    queue_trace(80);
    wait_idle();
    idle_on = 1'b1;

    // random settings, mostly narrow gates
    repeat (4) begin
      rnd_step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SAMPLE_MAX)
                                             : $urandom_range(0, 120);
      setup_filter(rnd_step, $urandom_range(0, 15), $urandom_range(0, TRIM_MAX));
      queue_trace(80);
      wait_idle();
    end

    // closing part runs flat out on both sides
    idle_on = 1'b0;
    setup_filter($urandom_range(8, 64), $urandom_range(1, 8), $urandom_range(0, TRIM_MAX));
    queue_trace(120);
    wait_idle();

    $display("ran %0d samples (%0d open probes, %0d gated holds), %0d results checked",
             samples_taken, opens_taken, holds_predicted, results_seen);
    $display("over %0d register settings incl. a %0d-cycle result hold-off",
             settings_applied, LONG_HOLD);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule : gated_trimmed_mean_filter_test

// File: sim.f
design/gtm_pkg.sv
design/gtm_in_if.sv
design/gtm_out_if.sv
design/gtm_ram.sv
design/gtm_stats.sv
design/gtm_div.sv
design/gated_trimmed_mean_filter.sv
verif/gated_trimmed_mean_filter_test.sv
